@@ rtl/core/modular_exponentiation_defines.svh @@
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property forms used by the sequencer and the multiplier
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// widths, register indexes, microcode format and program of the exponentiator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

    // operand width of the datapath and the fixed width of the ports
    localparam int WIDTH  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(WIDTH);

    // configuration register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // multiplier operations
    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_RED  = 2'd1;  // x = (1 * x) mod m
    localparam logic [1:0] MUL_RX   = 2'd2;  // r = (r * x) mod m
    localparam logic [1:0] MUL_XX   = 2'd3;  // x = (x * x) mod m

    // jump conditions
    localparam logic [2:0] COND_NONE    = 3'd0;
    localparam logic [2:0] COND_ALWAYS  = 3'd1;
    localparam logic [2:0] COND_M_SMALL = 3'd2;
    localparam logic [2:0] COND_E_ZERO  = 3'd3;
    localparam logic [2:0] COND_E_EVEN  = 3'd4;

    // program addresses
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_INIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_REDUCE = 3'd1;
    localparam logic [PC_W-1:0] PC_LOOP   = 3'd2;
    localparam logic [PC_W-1:0] PC_TEST   = 3'd3;
    localparam logic [PC_W-1:0] PC_MUL    = 3'd4;
    localparam logic [PC_W-1:0] PC_SQUARE = 3'd5;
    localparam logic [PC_W-1:0] PC_FIN    = 3'd6;
    localparam logic [PC_W-1:0] PC_ZERO   = 3'd7;

    // one control word
    typedef struct packed {
        logic [1:0]      mul_op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
        logic            shift_e;
        logic            fin;
        logic            fin_zero;
    } ucode_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic       mul_go;
        logic [1:0] mul_op;
        logic       shift_e;
        logic       fin;
        logic       fin_zero;
    } ctl_t;

    // datapath to sequencer status
    typedef struct packed {
        logic m_small;
        logic e_zero;
        logic e_lsb;
    } stat_t;

    // program rom: right-to-left square and multiply
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{mul_op: MUL_NONE, cond: COND_NONE, target: PC_INIT,
              shift_e: 1'b0, fin: 1'b0, fin_zero: 1'b0};
        case (pc)
            PC_INIT:
            begin
                w.cond   = COND_M_SMALL;
                w.target = PC_ZERO;
            end
            PC_REDUCE:
            begin
                w.mul_op = MUL_RED;
            end
            PC_LOOP:
            begin
                w.cond   = COND_E_ZERO;
                w.target = PC_FIN;
            end
            PC_TEST:
            begin
                w.cond   = COND_E_EVEN;
                w.target = PC_SQUARE;
            end
            PC_MUL:
            begin
                w.mul_op = MUL_RX;
            end
            PC_SQUARE:
            begin
                w.mul_op  = MUL_XX;
                w.shift_e = 1'b1;
                w.cond    = COND_ALWAYS;
                w.target  = PC_LOOP;
            end
            PC_FIN:
            begin
                w.fin = 1'b1;
            end
            PC_ZERO:
            begin
                w.fin_zero = 1'b1;
            end
            default:
            begin
                w.fin_zero = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module mexp_mulmod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [mexp_pkg::WIDTH-1:0]  a,
    input  logic [mexp_pkg::WIDTH-1:0]  b,
    input  logic [mexp_pkg::WIDTH-1:0]  m,
    output logic                        done,
    output logic [mexp_pkg::WIDTH-1:0]  product
);
    import mexp_pkg::*;

    localparam int SW = WIDTH + 2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] m_reg, m_next;

    logic [SW-1:0] sum;
    logic [SW-1:0] m1;
    logic [SW-1:0] m2;
    logic [SW-1:0] red;
    logic          last;

    // acc = 2*acc + bit*a, then take off m or 2m (sum stays below 3m)
    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[WIDTH-1] ? SW'(a_reg) : '0);
        m1  = SW'(m_reg);
        m2  = {1'b0, m_reg, 1'b0};
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    assign last = (cnt_reg == CNT_W'(WIDTH - 1));

    // step control and operand capture
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
        end
        else if (busy_reg)
        begin
            acc_next = red[WIDTH-1:0];
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `MEXP_ASSERT_NOW(a_mul_reduced, done_reg, acc_reg < m_reg,
        "mulmod product not below modulus")
    `MEXP_ASSERT_NOW(a_mul_no_overlap, go, !busy_reg,
        "mulmod started while busy")
    `MEXP_ASSERT_NEXT(a_mul_finish, busy_reg && last && !go, done_reg,
        "mulmod missed its done pulse")

endmodule

@@ rtl/core/mexp_seq.sv @@
// ----------------------------------------------------------------------------
// mexp_seq
// microcode sequencer: step counter, program rom and conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module mexp_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            launch,
    input  mexp_pkg::stat_t stat,
    input  logic            mul_done,
    output mexp_pkg::ctl_t  ctl,
    output logic            running
);
    import mexp_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            run_reg, run_next;
    logic            issued_reg, issued_next;

    ucode_t word;
    logic   has_mul;
    logic   step_end;
    logic   taken;

    assign word    = ucode_rom(pc_reg);
    assign has_mul = (word.mul_op != MUL_NONE);

    // a step with a multiply ends when the unit reports done
    assign step_end = run_reg && (!has_mul || (issued_reg && mul_done));

    // jump condition select
    always_comb
    begin
        case (word.cond)
            COND_NONE:    taken = 1'b0;
            COND_ALWAYS:  taken = 1'b1;
            COND_M_SMALL: taken = stat.m_small;
            COND_E_ZERO:  taken = stat.e_zero;
            COND_E_EVEN:  taken = !stat.e_lsb;
            default:      taken = 1'b0;
        endcase
    end

    // step counter and run flag
    always_comb
    begin
        pc_next     = pc_reg;
        run_next    = run_reg;
        issued_next = issued_reg;
        if (launch)
        begin
            pc_next     = PC_INIT;
            run_next    = 1'b1;
            issued_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (has_mul && !issued_reg)
            begin
                issued_next = 1'b1;
            end
            if (step_end)
            begin
                issued_next = 1'b0;
                pc_next     = taken ? word.target : pc_reg + 1'b1;
                if (word.fin || word.fin_zero)
                begin
                    run_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= PC_INIT;
            run_reg    <= 1'b0;
            issued_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            run_reg    <= run_next;
            issued_reg <= issued_next;
        end
    end

    // controls toward the datapath
    always_comb
    begin
        ctl.mul_go   = run_reg && has_mul && !issued_reg;
        ctl.mul_op   = word.mul_op;
        ctl.shift_e  = step_end && word.shift_e;
        ctl.fin      = step_end && word.fin;
        ctl.fin_zero = step_end && word.fin_zero;
    end

    assign running = run_reg;

    `MEXP_ASSERT_NEXT(a_seq_launch, launch, run_reg && (pc_reg == PC_INIT),
        "sequencer did not start at the first step")
    `MEXP_ASSERT_NEXT(a_seq_stop, ctl.fin || ctl.fin_zero, !run_reg,
        "sequencer kept running after the final step")
    `MEXP_ASSERT_NOW(a_seq_done_expected, mul_done, run_reg && issued_reg && has_mul,
        "multiplier done without an issued multiply")

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// base ** exponent mod modulus by right-to-left square and multiply
// ----------------------------------------------------------------------------
//  channel   ports                          transfer
//  input     start, busy, base              start high while busy low
//  result    done, residue                  done high, one cycle, no stall
//  config    cfg_we, cfg_idx, cfg_data      cfg_we high
//
//  each modular multiply runs through the bit-serial unit;
//  an item needs 1 + bits + ones multiplies,
//  bits the exponent length and ones its set bits
//  a modulus below two answers 0
//  reset clears the sequencer and sets exponent 1, modulus 2
//  the result is shown for one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mexp_pkg::DATA_W-1:0] base,
    input  logic                        cfg_we,
    input  logic                        cfg_idx,
    input  logic [mexp_pkg::DATA_W-1:0] cfg_data,
    output logic                        done,
    output logic [mexp_pkg::DATA_W-1:0] residue
);
    import mexp_pkg::*;

    logic [DATA_W-1:0] exponent_reg;
    logic [DATA_W-1:0] modulus_reg;

    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] m_reg;

    logic              done_reg;
    logic [DATA_W-1:0] residue_reg;

    logic             accept;
    logic             running;
    ctl_t             ctl;
    stat_t            stat;
    logic             mul_done;
    logic [WIDTH-1:0] product;
    logic [WIDTH-1:0] mul_a;

    assign accept = start && !running;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= DATA_W'(1);
            modulus_reg  <= DATA_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:      modulus_reg  <= modulus_reg;
            endcase
        end
    end

    // status toward the sequencer
    always_comb
    begin
        stat.m_small = (m_reg < WIDTH'(2));
        stat.e_zero  = (e_reg == '0);
        stat.e_lsb   = e_reg[0];
    end

    // multiplicand select; the multiplier is always x
    always_comb
    begin
        case (ctl.mul_op)
            MUL_RED: mul_a = WIDTH'(1);
            MUL_RX:  mul_a = r_reg;
            MUL_XX:  mul_a = x_reg;
            default: mul_a = x_reg;
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg <= WIDTH'(1);
            x_reg <= WIDTH'(base);
            e_reg <= WIDTH'(exponent_reg);
            m_reg <= WIDTH'(modulus_reg);
        end
        else
        begin
            if (mul_done)
            begin
                case (ctl.mul_op)
                    MUL_RX:  r_reg <= product;
                    MUL_RED: x_reg <= product;
                    MUL_XX:  x_reg <= product;
                    default: x_reg <= x_reg;
                endcase
            end
            if (ctl.shift_e)
            begin
                e_reg <= {1'b0, e_reg[WIDTH-1:1]};
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.fin || ctl.fin_zero;
        end
    end

    // result value
    always_ff @(posedge clk)
    begin
        if (ctl.fin)
        begin
            residue_reg <= DATA_W'(r_reg);
        end
        else if (ctl.fin_zero)
        begin
            residue_reg <= '0;
        end
    end

    mexp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (accept),
        .stat     (stat),
        .mul_done (mul_done),
        .ctl      (ctl),
        .running  (running)
    );

    mexp_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (ctl.mul_go),
        .a       (mul_a),
        .b       (x_reg),
        .m       (m_reg),
        .done    (mul_done),
        .product (product)
    );

    assign busy    = running;
    assign done    = done_reg;
    assign residue = residue_reg;

endmodule
